// ----- rtl/core/lmsr_pkg.sv -----
// ----------------------------------------------------------------------------
// lmsr_pkg
// Shared types and constants of the scrolling LED matrix renderer: word
// layouts, function and register codes, store geometry and the frame handed
// from the slot reader to the line emitter.
// ----------------------------------------------------------------------------
package lmsr_pkg;

  localparam int MAX_IMAGES  = 8;
  localparam int STORE_DEPTH = MAX_IMAGES + 4;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int IMG_W       = 64;
  localparam int ROW_W       = 8;
  localparam int LINE_W      = 16;
  localparam int CFG_DATA_W  = 4;

  // first image sits above two blank slots
  localparam logic [STORE_AW-1:0] IMG_BASE_SLOT = STORE_AW'(2);

  localparam logic [3:0] WINDOW_MAX     = 4'd8;
  localparam logic [3:0] STRIP_OFFSET   = 4'd12;
  localparam logic [3:0] LANDSCAPE_LAST = 4'd7;
  localparam logic [3:0] PORTRAIT_LAST  = 4'd11;

  // start view for a single image and for longer sequences
  localparam logic [STORE_AW-1:0] SINGLE_ELEMENT = STORE_AW'(1);
  localparam logic [3:0]          SINGLE_SHIFT   = 4'd6;
  localparam logic [STORE_AW-1:0] MULTI_ELEMENT  = STORE_AW'(2);
  localparam logic [3:0]          MULTI_SHIFT    = 4'd0;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_SCROLL = 2'd1,
    FUNC_STATIC = 2'd2,
    FUNC_HOME   = 2'd3
  } func_t;

  typedef enum logic {
    REG_ROTATION    = 1'b0,
    REG_IMAGE_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ROT_PORTRAIT_FLIP  = 2'd0,
    ROT_PORTRAIT       = 2'd1,
    ROT_LANDSCAPE      = 2'd2,
    ROT_LANDSCAPE_FLIP = 2'd3
  } rot_t;

  typedef enum logic {
    KIND_COLUMN = 1'b0,
    KIND_ROW    = 1'b1
  } line_kind_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_READ,
    C_WAIT,
    C_HAND
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [2:0]       image_index;
    logic [IMG_W-1:0] image_data;
  } in_word_t;

  typedef struct packed {
    logic              line_kind;
    logic [3:0]        line_index;
    logic [LINE_W-1:0] line_data;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [IMG_W-1:0]    wdata;
    logic                re;
    logic [STORE_AW-1:0] raddr;
  } store_req_t;

  typedef struct packed {
    logic [IMG_W-1:0] a;
    logic [IMG_W-1:0] b;
    logic [IMG_W-1:0] c;
    logic [3:0]       shift;
    logic [1:0]       rotation;
  } frame_t;

endpackage

// ----- rtl/core/led_matrix_scroll_renderer.sv -----
// ----------------------------------------------------------------------------
// led_matrix_scroll_renderer
// Scrolling LED matrix renderer: stores 8x8 images and renders a three-image
// window, shifted by 0..8 pixels, as column or row writes for a 12x8 grid.
//
//   channel  direction  handshake             word
//   in_      input      in_valid / in_ready   in_word_t (func, index, image)
//   out_     output     out_valid / out_ready out_word_t (one line write)
//   cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// A load or position reset is taken in the idle state and starts no render. A
// render reads its three slots through the store's single read port, then gives 8
// (landscape) or 12 (portrait) lines at one per cycle while out_ready holds; the
// slot reads of the next render overlap the lines of the current one. Reset
// clears the store's slot valid bits at once. A stalled out_ready holds the line
// register and, behind it, the frame and the input.
// ----------------------------------------------------------------------------
module led_matrix_scroll_renderer
  import lmsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  store_req_t       store_req;
  logic [IMG_W-1:0] store_rd_data;
  logic             frame_valid;
  frame_t           frame;
  logic             frame_take;

  lmsr_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (store_req),
    .rd_data (store_rd_data)
  );

  lmsr_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .store_req     (store_req),
    .store_rd_data (store_rd_data),
    .frame_valid   (frame_valid),
    .frame         (frame),
    .frame_take    (frame_take)
  );

  lmsr_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame_valid),
    .frame       (frame),
    .frame_take  (frame_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ----- rtl/core/lmsr_store.sv -----
// ----------------------------------------------------------------------------
// lmsr_store
// Image slot memory: one write port, one read port with registered data.
// Per-slot valid bits make unwritten slots read as blank after reset.
// ----------------------------------------------------------------------------
module lmsr_store
  import lmsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  store_req_t       req,
  output logic [IMG_W-1:0] rd_data
);

  logic [IMG_W-1:0]       mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_r;
  logic [IMG_W-1:0]       rd_raw_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_raw_r <= mem[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        rd_vld_r <= vld_r[req.raddr];
      end
    end
  end

  // blank slot until first written
  assign rd_data = rd_vld_r ? rd_raw_r : '0;

`ifndef SYNTH
  a_raddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    req.re |-> req.raddr < STORE_AW'(STORE_DEPTH))
    else $error("store read address out of range");
  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    req.we |-> req.waddr >= IMG_BASE_SLOT && req.waddr < STORE_AW'(MAX_IMAGES + 2))
    else $error("store write outside image slots");
  a_no_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.we && req.re))
    else $error("store written while a frame is being read");
`endif

endmodule

// ----- rtl/core/lmsr_ctrl.sv -----
// ----------------------------------------------------------------------------
// lmsr_ctrl
// Input front end: takes words, writes loads into the store, keeps the scroll
// position and the configuration, and for a render reads three consecutive
// slots into a frame for the line emitter.
// ----------------------------------------------------------------------------
module lmsr_ctrl
  import lmsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output store_req_t            store_req,
  input  logic [IMG_W-1:0]      store_rd_data,
  output logic                  frame_valid,
  output frame_t                frame,
  input  logic                  frame_take
);

  ctrl_state_t           state_r, state_nxt;
  logic [1:0]            rotation_r;
  logic [3:0]            image_count_r;
  logic [STORE_AW-1:0]   scroll_element_r, scroll_element_nxt;
  logic [3:0]            scroll_window_r, scroll_window_nxt;
  logic [STORE_AW-1:0]   base_r;
  logic [1:0]            rd_cnt_r;
  logic                  rd_pend_r;
  logic [1:0]            rd_slot_r;
  frame_t                frm_r;

  logic                  accept;
  logic                  is_render;
  logic [3:0]            eff_count;
  logic [3:0]            win_inc;
  logic [STORE_AW-1:0]   elem_inc;
  logic [STORE_AW-1:0]   render_elem;
  logic [3:0]            render_shift;

  assign accept    = in_valid && in_ready;
  assign is_render = (in_data.func == FUNC_SCROLL) || (in_data.func == FUNC_STATIC);

  // count used for wrap saturates at MAX_IMAGES
  assign eff_count = (image_count_r > 4'(MAX_IMAGES)) ? 4'(MAX_IMAGES) : image_count_r;
  assign win_inc   = scroll_window_r + 4'd1;
  assign elem_inc  = scroll_element_r + STORE_AW'(1);

  always_comb begin
    scroll_element_nxt = scroll_element_r;
    scroll_window_nxt  = scroll_window_r;
    if (accept && in_data.func == FUNC_SCROLL) begin
      scroll_window_nxt = win_inc;
      if (win_inc > WINDOW_MAX) begin
        scroll_window_nxt  = 4'd1;
        scroll_element_nxt = elem_inc;
        if (5'(elem_inc) > 5'(eff_count) + 5'd1) begin
          scroll_element_nxt = '0;
        end
      end
    end else if (accept && in_data.func == FUNC_HOME) begin
      scroll_window_nxt  = '0;
      scroll_element_nxt = '0;
    end
  end

  always_comb begin
    if (in_data.func == FUNC_STATIC) begin
      if (image_count_r == 4'd1) begin
        render_elem  = SINGLE_ELEMENT;
        render_shift = SINGLE_SHIFT;
      end else begin
        render_elem  = MULTI_ELEMENT;
        render_shift = MULTI_SHIFT;
      end
    end else begin
      render_elem  = scroll_element_r;
      render_shift = scroll_window_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_IDLE: begin
        if (accept && is_render) begin
          state_nxt = C_READ;
        end
      end
      C_READ: begin
        if (rd_cnt_r == 2'd2) begin
          state_nxt = C_WAIT;
        end
      end
      C_WAIT: state_nxt = C_HAND;
      C_HAND: begin
        if (frame_take) begin
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready        = 1'b0;
    frame_valid     = 1'b0;
    store_req.we    = 1'b0;
    store_req.waddr = STORE_AW'(in_data.image_index) + IMG_BASE_SLOT;
    store_req.wdata = in_data.image_data;
    store_req.re    = 1'b0;
    store_req.raddr = base_r + STORE_AW'(rd_cnt_r);
    case (state_r)
      C_IDLE: begin
        in_ready     = 1'b1;
        store_req.we = in_valid && in_data.func == FUNC_LOAD
                       && 4'(in_data.image_index) < 4'(MAX_IMAGES);
      end
      C_READ:  store_req.re = 1'b1;
      C_WAIT:  ;
      C_HAND:  frame_valid = 1'b1;
      default: ;
    endcase
  end

  assign frame = frm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= C_IDLE;
      rotation_r       <= ROT_LANDSCAPE_FLIP;
      image_count_r    <= '0;
      scroll_element_r <= '0;
      scroll_window_r  <= '0;
      rd_cnt_r         <= '0;
      rd_pend_r        <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      scroll_element_r <= scroll_element_nxt;
      scroll_window_r  <= scroll_window_nxt;
      rd_pend_r        <= (state_r == C_READ);
      if (cfg_we && cfg_index == REG_ROTATION) begin
        rotation_r <= cfg_wdata[1:0];
      end
      if (cfg_we && cfg_index == REG_IMAGE_COUNT) begin
        image_count_r <= cfg_wdata;
      end
      if (accept) begin
        rd_cnt_r <= '0;
      end else if (state_r == C_READ) begin
        rd_cnt_r <= rd_cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_r <= rd_cnt_r;
    if (accept && is_render) begin
      base_r         <= render_elem;
      frm_r.shift    <= render_shift;
      frm_r.rotation <= rotation_r;
    end
    // capture slot data in the cycle after its read
    if (rd_pend_r) begin
      case (rd_slot_r)
        2'd0:    frm_r.a <= store_rd_data;
        2'd1:    frm_r.b <= store_rd_data;
        2'd2:    frm_r.c <= store_rd_data;
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
    scroll_window_r <= WINDOW_MAX)
    else $error("scroll window beyond range");
  a_element_range: assert property (@(posedge clk) disable iff (!rst_n)
    5'(scroll_element_r) <= 5'(MAX_IMAGES + 1))
    else $error("scroll element beyond range");
  a_wait_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == C_WAIT |-> $past(state_r) == C_READ && $past(rd_cnt_r) == 2'd2)
    else $error("frame handed over before all slots read");
`endif

endmodule

// ----- rtl/core/lmsr_emit.sv -----
// ----------------------------------------------------------------------------
// lmsr_emit
// Line emitter: holds one frame and produces one column or row write per
// cycle into an output register while the output is not stalled; takes the
// next frame when idle or as the last line of the current one is produced.
// ----------------------------------------------------------------------------
module lmsr_emit
  import lmsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      frame_valid,
  input  frame_t    frame,
  output logic      frame_take,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  frame_t     frm_r;
  logic       busy_r;
  logic [3:0] cnt_r;
  logic       out_valid_r;
  out_word_t  out_word_r;

  logic       gen;
  logic       landscape;
  logic [3:0] last_cnt;
  logic       at_last;
  out_word_t  line;

  function automatic logic [ROW_W-1:0] rev8(input logic [ROW_W-1:0] v);
    logic [ROW_W-1:0] r;
    for (int i = 0; i < ROW_W; i++) begin
      r[i] = v[ROW_W-1-i];
    end
    return r;
  endfunction

  assign landscape  = frm_r.rotation[1];
  assign last_cnt   = landscape ? LANDSCAPE_LAST : PORTRAIT_LAST;
  assign at_last    = (cnt_r == last_cnt);
  assign gen        = busy_r && (!out_valid_r || out_ready);
  assign frame_take = frame_valid && (!busy_r || (gen && at_last));

  // line for the current beat
  logic [ROW_W-1:0]   ra, rb, rc, rp;
  logic [3*ROW_W-1:0] w24;
  logic [3:0]         sh;
  logic [4:0]         strip_idx;
  logic [2:0]         prow;
  logic [ROW_W-1:0]   pbyte;

  always_comb begin
    ra = frm_r.a[{cnt_r[2:0], 3'b000} +: ROW_W];
    rb = frm_r.b[{cnt_r[2:0], 3'b000} +: ROW_W];
    rc = frm_r.c[{cnt_r[2:0], 3'b000} +: ROW_W];
    if (frm_r.rotation == ROT_LANDSCAPE_FLIP) begin
      ra = rev8(ra);
      rb = rev8(rb);
      rc = rev8(rc);
    end
    if (frm_r.rotation[0]) begin
      w24 = {ra, rb, rc};
      sh  = STRIP_OFFSET - frm_r.shift;
    end else begin
      w24 = {rc, rb, ra};
      sh  = frm_r.shift;
    end

    // strip row: A above B above C, each stored top row first
    strip_idx = 5'(cnt_r) + 5'(STRIP_OFFSET) - 5'(frm_r.shift);
    prow      = 3'd7 - strip_idx[2:0];
    case (strip_idx[4:3])
      2'd2:    pbyte = frm_r.a[{prow, 3'b000} +: ROW_W];
      2'd1:    pbyte = frm_r.b[{prow, 3'b000} +: ROW_W];
      default: pbyte = frm_r.c[{prow, 3'b000} +: ROW_W];
    endcase
    rp = (frm_r.rotation == ROT_PORTRAIT_FLIP) ? rev8(pbyte) : pbyte;

    line.last = at_last;
    if (landscape) begin
      line.line_kind  = KIND_COLUMN;
      line.line_index = frm_r.rotation[0] ? (LANDSCAPE_LAST - cnt_r) : cnt_r;
      line.line_data  = LINE_W'(w24 >> sh);
    end else begin
      line.line_kind  = KIND_ROW;
      line.line_index = frm_r.rotation[0] ? cnt_r : (PORTRAIT_LAST - cnt_r);
      line.line_data  = {{(LINE_W-ROW_W){1'b0}}, rp};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (gen) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (frame_take) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (gen) begin
        if (at_last) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      frm_r <= frame;
    end
    if (gen) begin
      out_word_r <= line;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

`ifndef SYNTH
  a_take_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    frame_take |=> busy_r && cnt_r == 4'd0)
    else $error("frame taken without restarting line count");
  a_landscape_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && landscape |-> cnt_r <= LANDSCAPE_LAST)
    else $error("landscape frame beyond eight columns");
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    gen && at_last |=> out_valid_r && out_word_r.last)
    else $error("final line of frame not flagged");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scrolling LED matrix renderer. A queue-fed
// driver offers function words, a line predictor works out the column or row
// writes each accepted word must produce, and a monitor checks every line
// write against the oldest predicted one. Phases sweep rotation and image
// count, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import lmsr_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int SETTLE      = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 400;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = REG_ROTATION;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor copy of the block state
  logic [IMG_W-1:0] img_slots [STORE_DEPTH];
  int               view_elem;
  int               view_shift;
  logic [1:0]       cur_rot = ROT_LANDSCAPE_FLIP;
  logic [3:0]       cur_count = 4'd0;

  in_word_t  word_q [$];
  out_word_t line_q [$];
  out_word_t want_line;

  int words_queued = 0;
  int words_taken = 0;
  int lines_seen = 0;
  int errors = 0;
  int cycles = 0;
  int send_gap = 0;
  int ready_gap = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  bit calm = 1'b0;

  led_matrix_scroll_renderer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  function automatic logic [7:0] mirror8(logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = b[i];
    return r;
  endfunction

  function automatic logic [IMG_W-1:0] slot_image(int s);
    return (s < STORE_DEPTH) ? img_slots[s] : '0;
  endfunction

  // Queue the line writes of one frame built from slots elem..elem+2.
  task automatic render_lines(int elem, int shift);
    logic [IMG_W-1:0] a, b, c;
    logic [7:0]       ra, rb, rc;
    logic [23:0]      w;
    logic [7:0]       strip [24];
    out_word_t        o;
    bit               flip;
    int               sh;
    a = slot_image(elem);
    b = slot_image(elem + 1);
    c = slot_image(elem + 2);
    sh = (shift > 12) ? 12 : shift;
    flip = (cur_rot == ROT_LANDSCAPE_FLIP) || (cur_rot == ROT_PORTRAIT_FLIP);
    for (int r = 0; r < 8; r++) begin
      ra = a[r*8 +: 8];
      rb = b[r*8 +: 8];
      rc = c[r*8 +: 8];
      if (flip) begin
        ra = mirror8(ra);
        rb = mirror8(rb);
        rc = mirror8(rc);
      end
      if (cur_rot[1]) begin
        o.line_kind = KIND_COLUMN;
        o.last = (r == 7);
        if (cur_rot[0]) begin
          w = {ra, rb, rc};
          o.line_index = 4'(7 - r);
          o.line_data = 16'(w >> (12 - sh));
        end else begin
          w = {rc, rb, ra};
          o.line_index = 4'(r);
          o.line_data = 16'(w >> sh);
        end
        line_q.push_back(o);
      end else begin
        strip[23-r] = ra;
        strip[15-r] = rb;
        strip[7-r] = rc;
      end
    end
    if (!cur_rot[1]) begin
      for (int d = 0; d < 12; d++) begin
        o.line_kind = KIND_ROW;
        o.line_index = cur_rot[0] ? 4'(d) : 4'(11 - d);
        o.line_data = {8'h00, strip[d + 12 - sh]};
        o.last = (d == 11);
        line_q.push_back(o);
      end
    end
  endtask

  task automatic predict_word(in_word_t w);
    int top;
    top = (cur_count > MAX_IMAGES) ? MAX_IMAGES : int'(cur_count);
    case (func_t'(w.func))
      FUNC_LOAD: begin
        if (w.image_index < MAX_IMAGES) img_slots[int'(w.image_index) + 2] = w.image_data;
      end
      FUNC_SCROLL: begin
        render_lines(view_elem, view_shift);
        view_shift++;
        if (view_shift > WINDOW_MAX) begin
          view_shift = 1;
          view_elem++;
          if (view_elem > top + 1) view_elem = 0;
        end
      end
      FUNC_STATIC: begin
        if (cur_count == 4'd1) render_lines(SINGLE_ELEMENT, SINGLE_SHIFT);
        else render_lines(MULTI_ELEMENT, MULTI_SHIFT);
      end
      default: begin
        view_elem = 0;
        view_shift = 0;
      end
    endcase
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_word(in_data);
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (word_q.size() > 0) begin
          in_data <= word_q.pop_front();
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      ready_gap = $urandom_range(1, 15) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // line checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      lines_seen++;
      if (line_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected line write expected none, actual kind=%0d index=%0d %s",
                 $time, out_data.line_kind, out_data.line_index,
                 $sformatf("data=%h last=%0d", out_data.line_data, out_data.last));
      end else begin
        want_line = line_q.pop_front();
        if (out_data.line_kind !== want_line.line_kind ||
            out_data.line_index !== want_line.line_index ||
            out_data.line_data !== want_line.line_data ||
            out_data.last !== want_line.last) begin
          errors++;
          $write("%0t: line mismatch expected kind=%0d index=%0d data=%h last=%0d, ",
                 $time, want_line.line_kind, want_line.line_index, want_line.line_data,
                 want_line.last);
          $display("actual kind=%0d index=%0d data=%h last=%0d",
                   out_data.line_kind, out_data.line_index, out_data.line_data,
                   out_data.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic push_word(func_t f, logic [2:0] idx, logic [IMG_W-1:0] data);
    in_word_t w;
    w.func = f;
    w.image_index = idx;
    w.image_data = data;
    word_q.push_back(w);
    words_queued++;
  endtask

  task automatic push_random(bit heavy);
    logic [IMG_W-1:0] data;
    int               pick;
    func_t            f;
    data = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 2))
        0: data = '1;
        1: data = '0;
        default: data = 64'd1 << $urandom_range(0, 63);
      endcase
    end
    pick = $urandom_range(0, 99);
    if (pick < 2) f = FUNC_HOME;
    else if (pick < (heavy ? 82 : 52)) f = FUNC_SCROLL;
    else if (pick < (heavy ? 90 : 75)) f = FUNC_STATIC;
    else f = FUNC_LOAD;
    push_word(f, 3'($urandom_range(0, 7)), data);
  endtask

  task automatic write_regs(logic [1:0] rot, logic [3:0] cnt);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_ROTATION;
    cfg_wdata <= {2'b00, rot};
    @(posedge clk);
    cfg_index <= REG_IMAGE_COUNT;
    cfg_wdata <= cnt;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_rot = rot;
    cur_count = cnt;
  endtask

  // wait for every word to be taken and every line to come back
  task automatic settle();
    while (words_taken != words_queued || line_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_phase(logic [1:0] rot, logic [3:0] cnt, int n, bit heavy);
    write_regs(rot, cnt);
    for (int i = 0; i < n; i++) push_random(heavy);
    settle();
  endtask

  initial begin
    for (int s = 0; s < STORE_DEPTH; s++) img_slots[s] = '0;
    view_elem = 0;
    view_shift = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty store, field extremes, window wrap, every function
    write_regs(ROT_LANDSCAPE_FLIP, 4'd8);
    push_word(FUNC_STATIC, 3'd0, '0);
    push_word(FUNC_LOAD, 3'd0, '1);
    push_word(FUNC_LOAD, 3'd7, '1);
    push_word(FUNC_LOAD, 3'd3, 64'hAAAA_AAAA_AAAA_AAAA);
    push_word(FUNC_LOAD, 3'd1, 64'h0123_4567_89AB_CDEF);
    push_word(FUNC_LOAD, 3'd2, 64'h8000_0000_0000_0001);
    for (int i = 0; i < 9; i++) push_word(FUNC_SCROLL, 3'd0, '0);
    push_word(FUNC_STATIC, 3'd7, '1);
    push_word(FUNC_HOME, 3'd5, 64'h5555_5555_5555_5555);
    push_word(FUNC_SCROLL, 3'd0, '0);
    push_word(FUNC_LOAD, 3'd7, '0);
    push_word(FUNC_SCROLL, 3'd0, '0);
    settle();

    random_phase(ROT_LANDSCAPE, 4'd0, 40, 1'b1);
    random_phase(ROT_PORTRAIT_FLIP, 4'd8, 60, 1'b0);
    // stall the output long enough to back up into the input channel
    hold_req = 1'b1;
    random_phase(ROT_PORTRAIT, 4'd1, 60, 1'b1);
    // oversized count: start from home so the element wraps at the cap
    push_word(FUNC_HOME, 3'd0, '0);
    settle();
    random_phase(ROT_LANDSCAPE_FLIP, 4'd15, 110, 1'b1);
    random_phase(ROT_PORTRAIT_FLIP, 4'd0, 40, 1'b0);
    random_phase(ROT_PORTRAIT, 4'd8, 40, 1'b0);
    random_phase(ROT_LANDSCAPE, 4'd1, 40, 1'b0);
    calm = 1'b1;
    random_phase(ROT_LANDSCAPE_FLIP, 4'd12, 40, 1'b0);

    $display("Run drove %0d function words and checked %0d line writes", words_taken,
             lines_seen);
    $display("across all four rotations and image counts 0, 1, 8, 12 and 15");
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/lmsr_pkg.sv
rtl/core/lmsr_store.sv
rtl/core/lmsr_ctrl.sv
rtl/core/lmsr_emit.sv
rtl/core/led_matrix_scroll_renderer.sv
verif/tb_top.sv
